>>> design/cau_pkg.sv
`default_nettype none
package cau_pkg;

   // Operation codes carried in the kind field.
   typedef enum logic [1:0] {
      KIND_ADD = 2'd0,
      KIND_SUB = 2'd1,
      KIND_MUL = 2'd2,
      KIND_DIV = 2'd3
   } kind_type;

   // Per-transaction control that travels down the pipeline.
   typedef struct packed {
      logic is_div;
      logic div_by_zero;
   } flags_type;

endpackage
`default_nettype wire

>>> design/cau_if.sv
`default_nettype none
// Request channel: operation and two complex operands.
interface cau_req_if #(parameter int WIDTH = 16);
   logic                    valid;
   logic                    ready;
   logic [1:0]              kind;
   logic signed [WIDTH-1:0] a_re;
   logic signed [WIDTH-1:0] a_im;
   logic signed [WIDTH-1:0] b_re;
   logic signed [WIDTH-1:0] b_im;

   modport source (output valid, kind, a_re, a_im, b_re, b_im, input ready);
   modport sink (input valid, kind, a_re, a_im, b_re, b_im, output ready);
endinterface

// Response channel: complex result and status flags.
interface cau_rsp_if #(parameter int WIDTH = 16);
   logic                    valid;
   logic                    ready;
   logic signed [WIDTH-1:0] res_re;
   logic signed [WIDTH-1:0] res_im;
   logic                    overflow;
   logic                    div_by_zero;

   modport source (output valid, res_re, res_im, overflow, div_by_zero, input ready);
   modport sink (input valid, res_re, res_im, overflow, div_by_zero, output ready);
endinterface
`default_nettype wire

>>> design/cau_front.sv
`default_nettype none
// Front end: products in the first stage, exact sums as sign and magnitude in the second.
module cau_front
   import cau_pkg::*;
#(
   parameter int WIDTH     = 16,
   parameter int FRAC_BITS = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   cau_req_if.sink                req_chan,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output flags_type              out_flags,
   output logic                   out_neg_re,
   output logic                   out_neg_im,
   output logic [2*WIDTH:0]       out_mag_re,
   output logic [2*WIDTH:0]       out_mag_im,
   output logic [2*WIDTH:0]       out_den
);
   localparam int PW = 2 * WIDTH;

   logic                    a_valid_ff;
   kind_type                kind_ff;
   logic signed [WIDTH-1:0] are_ff, aim_ff, bre_ff, bim_ff;
   logic signed [PW-1:0]    p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff, s_r_ff, s_i_ff;

   logic                    b_valid_ff;
   flags_type               flags_ff;
   logic                    neg_re_ff, neg_im_ff;
   logic [PW:0]             mag_re_ff, mag_im_ff, den_ff;

   logic                    adv_a, adv_b;
   logic signed [PW:0]      val_re_in, val_im_in;
   logic [PW:0]             den_in, abs_re, abs_im, mag_re_in, mag_im_in;
   logic                    neg_re_in, neg_im_in;
   flags_type               flags_in;

   // Stall chain: a stage moves when it is empty or its successor moves.
   assign adv_b          = !b_valid_ff || out_ready;
   assign adv_a          = !a_valid_ff || adv_b;
   assign req_chan.ready = adv_a;

   // Stage A valid bit.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv_a) begin
         a_valid_ff <= req_chan.valid;
      end
   end

   // Stage A payload: operands and the six partial products.
   always_ff @(posedge clock) begin
      if (adv_a) begin
         kind_ff <= kind_type'(req_chan.kind);
         are_ff  <= req_chan.a_re;
         aim_ff  <= req_chan.a_im;
         bre_ff  <= req_chan.b_re;
         bim_ff  <= req_chan.b_im;
         p_rr_ff <= req_chan.a_re * req_chan.b_re;
         p_ii_ff <= req_chan.a_im * req_chan.b_im;
         p_ri_ff <= req_chan.a_re * req_chan.b_im;
         p_ir_ff <= req_chan.a_im * req_chan.b_re;
         s_r_ff  <= req_chan.b_re * req_chan.b_re;
         s_i_ff  <= req_chan.b_im * req_chan.b_im;
      end
   end

   // Stage B logic: exact real and imaginary sums per operation.
   always_comb begin
      den_in = {1'b0, s_r_ff} + {1'b0, s_i_ff};
      unique case (kind_ff)
         KIND_ADD: begin
            val_re_in = {{(WIDTH+1){are_ff[WIDTH-1]}}, are_ff}
                      + {{(WIDTH+1){bre_ff[WIDTH-1]}}, bre_ff};
            val_im_in = {{(WIDTH+1){aim_ff[WIDTH-1]}}, aim_ff}
                      + {{(WIDTH+1){bim_ff[WIDTH-1]}}, bim_ff};
         end
         KIND_SUB: begin
            val_re_in = {{(WIDTH+1){are_ff[WIDTH-1]}}, are_ff}
                      - {{(WIDTH+1){bre_ff[WIDTH-1]}}, bre_ff};
            val_im_in = {{(WIDTH+1){aim_ff[WIDTH-1]}}, aim_ff}
                      - {{(WIDTH+1){bim_ff[WIDTH-1]}}, bim_ff};
         end
         KIND_MUL: begin
            val_re_in = {p_rr_ff[PW-1], p_rr_ff} - {p_ii_ff[PW-1], p_ii_ff};
            val_im_in = {p_ri_ff[PW-1], p_ri_ff} + {p_ir_ff[PW-1], p_ir_ff};
         end
         KIND_DIV: begin
            val_re_in = {p_rr_ff[PW-1], p_rr_ff} + {p_ii_ff[PW-1], p_ii_ff};
            val_im_in = {p_ir_ff[PW-1], p_ir_ff} - {p_ri_ff[PW-1], p_ri_ff};
         end
         default: begin
            val_re_in = '0;
            val_im_in = '0;
         end
      endcase

      abs_re = val_re_in[PW] ? (PW+1)'(-val_re_in) : val_re_in;
      abs_im = val_im_in[PW] ? (PW+1)'(-val_im_in) : val_im_in;
      mag_re_in = abs_re;
      mag_im_in = abs_im;
      flags_in.is_div      = 1'b0;
      flags_in.div_by_zero = 1'b0;

      // Products drop the fraction toward zero; a zero quotient by zero is flagged.
      if (kind_ff == KIND_MUL) begin
         mag_re_in = abs_re >> FRAC_BITS;
         mag_im_in = abs_im >> FRAC_BITS;
      end else if (kind_ff == KIND_DIV) begin
         if (den_in == '0) begin
            flags_in.div_by_zero = 1'b1;
            mag_re_in = '0;
            mag_im_in = '0;
         end else begin
            flags_in.is_div = 1'b1;
         end
      end
      neg_re_in = val_re_in[PW] && (mag_re_in != '0);
      neg_im_in = val_im_in[PW] && (mag_im_in != '0);
   end

   // Stage B valid bit.
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (adv_b) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   // Stage B payload.
   always_ff @(posedge clock) begin
      if (adv_b) begin
         flags_ff  <= flags_in;
         neg_re_ff <= neg_re_in;
         neg_im_ff <= neg_im_in;
         mag_re_ff <= mag_re_in;
         mag_im_ff <= mag_im_in;
         den_ff    <= den_in;
      end
   end

   assign out_valid  = b_valid_ff;
   assign out_flags  = flags_ff;
   assign out_neg_re = neg_re_ff;
   assign out_neg_im = neg_im_ff;
   assign out_mag_re = mag_re_ff;
   assign out_mag_im = mag_im_ff;
   assign out_den    = den_ff;

endmodule
`default_nettype wire

>>> design/cau_div.sv
`default_nettype none
// Pipelined restoring divider: a range check stage, then one quotient bit per stage.
module cau_div
   import cau_pkg::*;
#(
   parameter int WIDTH     = 16,
   parameter int FRAC_BITS = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire flags_type         in_flags,
   input  wire logic              in_neg_re,
   input  wire logic              in_neg_im,
   input  wire logic [2*WIDTH:0]  in_mag_re,
   input  wire logic [2*WIDTH:0]  in_mag_im,
   input  wire logic [2*WIDTH:0]  in_den,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output flags_type              out_flags,
   output logic                   out_neg_re,
   output logic                   out_neg_im,
   output logic [2*WIDTH:0]       out_mag_re,
   output logic [2*WIDTH:0]       out_mag_im
);
   localparam int PW     = 2 * WIDTH;
   localparam int XW     = 3 * WIDTH + FRAC_BITS + 1;
   localparam int STAGES = WIDTH + 1;

   logic                   valid_ff [STAGES];
   flags_type              flags_ff [STAGES];
   logic [1:0]             neg_ff   [STAGES];
   logic [PW:0]            mag_ff   [STAGES][2];
   logic [PW:0]            den_ff   [STAGES];
   logic [XW-1:0]          rem_ff   [STAGES][2];
   logic [WIDTH-1:0]       quo_ff   [STAGES][2];
   logic [1:0]             big_ff   [STAGES];
   logic                   adv      [STAGES+1];

   assign adv[STAGES] = out_ready;
   assign in_ready    = adv[0];

   genvar k, s;
   generate
      for (k = 0; k < STAGES; k++) begin : g_stage
         logic [XW-1:0]    rem_in [2];
         logic [WIDTH-1:0] quo_in [2];
         logic             big_in [2];
         logic             valid_prev;
         flags_type        flags_prev;
         logic [1:0]       neg_prev;
         logic [PW:0]      mag_prev [2];
         logic [PW:0]      den_prev;

         assign adv[k] = !valid_ff[k] || adv[k+1];

         if (k == 0) begin : g_src_in
            assign valid_prev  = in_valid;
            assign flags_prev  = in_flags;
            assign neg_prev    = {in_neg_im, in_neg_re};
            assign mag_prev[0] = in_mag_re;
            assign mag_prev[1] = in_mag_im;
            assign den_prev    = in_den;
         end else begin : g_src_stage
            assign valid_prev  = valid_ff[k-1];
            assign flags_prev  = flags_ff[k-1];
            assign neg_prev    = neg_ff[k-1];
            assign mag_prev[0] = mag_ff[k-1][0];
            assign mag_prev[1] = mag_ff[k-1][1];
            assign den_prev    = den_ff[k-1];
         end

         for (s = 0; s < 2; s++) begin : g_part
            logic [XW-1:0] num_x, dsh_x;
            if (k == 0) begin : g_check
               // Quotients of 2^WIDTH or more saturate in any case.
               always_comb begin
                  num_x     = XW'(mag_prev[s]) << FRAC_BITS;
                  dsh_x     = XW'(den_prev) << WIDTH;
                  rem_in[s] = num_x;
                  quo_in[s] = '0;
                  big_in[s] = num_x >= dsh_x;
               end
            end else begin : g_bit
               // Trial subtract of the divisor shifted to this quotient bit.
               always_comb begin
                  num_x     = rem_ff[k-1][s];
                  dsh_x     = XW'(den_prev) << (WIDTH - k);
                  rem_in[s] = num_x;
                  quo_in[s] = quo_ff[k-1][s];
                  big_in[s] = big_ff[k-1][s];
                  if (num_x >= dsh_x) begin
                     rem_in[s]            = num_x - dsh_x;
                     quo_in[s][WIDTH - k] = 1'b1;
                  end
               end
            end
         end

         // Valid bit of this stage.
         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[k] <= 1'b0;
            end else if (adv[k]) begin
               valid_ff[k] <= valid_prev;
            end
         end

         // Payload of this stage.
         always_ff @(posedge clock) begin
            if (adv[k]) begin
               flags_ff[k]  <= flags_prev;
               neg_ff[k]    <= neg_prev;
               mag_ff[k][0] <= mag_prev[0];
               mag_ff[k][1] <= mag_prev[1];
               den_ff[k]    <= den_prev;
               rem_ff[k][0] <= rem_in[0];
               rem_ff[k][1] <= rem_in[1];
               quo_ff[k][0] <= quo_in[0];
               quo_ff[k][1] <= quo_in[1];
               big_ff[k]    <= {big_in[1], big_in[0]};
            end
         end
      end
   endgenerate

   // Select the quotient for divide transactions; others pass their magnitude.
   always_comb begin
      out_valid  = valid_ff[STAGES-1];
      out_flags  = flags_ff[STAGES-1];
      out_mag_re = mag_ff[STAGES-1][0];
      out_mag_im = mag_ff[STAGES-1][1];
      if (flags_ff[STAGES-1].is_div) begin
         out_mag_re = big_ff[STAGES-1][0] ? {1'b1, {PW{1'b0}}}
                                         : (PW+1)'(quo_ff[STAGES-1][0]);
         out_mag_im = big_ff[STAGES-1][1] ? {1'b1, {PW{1'b0}}}
                                         : (PW+1)'(quo_ff[STAGES-1][1]);
      end
      out_neg_re = neg_ff[STAGES-1][0] && (out_mag_re != '0);
      out_neg_im = neg_ff[STAGES-1][1] && (out_mag_im != '0);
   end

endmodule
`default_nettype wire

>>> design/complex_arithmetic_unit.sv
`default_nettype none
// Complex arithmetic unit: add, subtract, multiply and divide of complex
// operands in signed fixed point (WIDTH bits, FRAC_BITS fraction bits).
// A request transaction on req_chan carries the operation code and the
// operands a and b; each one yields exactly one response transaction on
// rsp_chan with the result parts and the overflow and divide-by-zero flags.
// Both channels use valid/ready; a transaction moves when both are high.
// Every operation passes the same stages: the product stage and the sum stage
// of the front end, the divider stages (a range check, then one quotient bit
// per stage) and the saturating output register. Throughput is one
// transaction per cycle while rsp_chan is ready. When rsp_chan stalls, the
// result holds in the output register and the stages behind it keep filling
// empty slots; req_chan.ready falls only when every stage holds a
// transaction. Reset clears all valid bits; the block keeps no other state.
module complex_arithmetic_unit
   import cau_pkg::*;
#(
   parameter int WIDTH     = 16,
   parameter int FRAC_BITS = 8
) (
   input  wire logic clock,
   input  wire logic reset,
   cau_req_if.sink   req_chan,
   cau_rsp_if.source rsp_chan
);
   localparam int PW = 2 * WIDTH;

   logic              f_valid, f_ready, d_valid, d_ready;
   flags_type         f_flags, d_flags;
   logic              f_neg_re, f_neg_im, d_neg_re, d_neg_im;
   logic [PW:0]       f_mag_re, f_mag_im, f_den, d_mag_re, d_mag_im;

   logic              out_valid_ff;
   logic [WIDTH-1:0]  res_re_ff, res_im_ff, res_re_in, res_im_in;
   logic              ovf_ff, dz_ff, ovf_re, ovf_im;

   cau_front #(.WIDTH(WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .out_valid  (f_valid),
      .out_ready  (f_ready),
      .out_flags  (f_flags),
      .out_neg_re (f_neg_re),
      .out_neg_im (f_neg_im),
      .out_mag_re (f_mag_re),
      .out_mag_im (f_mag_im),
      .out_den    (f_den)
   );

   cau_div #(.WIDTH(WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (f_valid),
      .in_ready   (f_ready),
      .in_flags   (f_flags),
      .in_neg_re  (f_neg_re),
      .in_neg_im  (f_neg_im),
      .in_mag_re  (f_mag_re),
      .in_mag_im  (f_mag_im),
      .in_den     (f_den),
      .out_valid  (d_valid),
      .out_ready  (d_ready),
      .out_flags  (d_flags),
      .out_neg_re (d_neg_re),
      .out_neg_im (d_neg_im),
      .out_mag_re (d_mag_re),
      .out_mag_im (d_mag_im)
   );

   assign d_ready = !out_valid_ff || rsp_chan.ready;

   // Saturate each part to the WIDTH-bit range.
   always_comb begin
      ovf_re    = 1'b0;
      ovf_im    = 1'b0;
      res_re_in = WIDTH'(-d_mag_re);
      res_im_in = WIDTH'(-d_mag_im);
      if (!d_neg_re) begin
         res_re_in = d_mag_re[WIDTH-1:0];
         if (d_mag_re > (PW+1)'({1'b0, {(WIDTH-1){1'b1}}})) begin
            ovf_re    = 1'b1;
            res_re_in = {1'b0, {(WIDTH-1){1'b1}}};
         end
      end else if (d_mag_re > (PW+1)'({1'b1, {(WIDTH-1){1'b0}}})) begin
         ovf_re    = 1'b1;
         res_re_in = {1'b1, {(WIDTH-1){1'b0}}};
      end
      if (!d_neg_im) begin
         res_im_in = d_mag_im[WIDTH-1:0];
         if (d_mag_im > (PW+1)'({1'b0, {(WIDTH-1){1'b1}}})) begin
            ovf_im    = 1'b1;
            res_im_in = {1'b0, {(WIDTH-1){1'b1}}};
         end
      end else if (d_mag_im > (PW+1)'({1'b1, {(WIDTH-1){1'b0}}})) begin
         ovf_im    = 1'b1;
         res_im_in = {1'b1, {(WIDTH-1){1'b0}}};
      end
   end

   // Output register valid bit.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (d_ready) begin
         out_valid_ff <= d_valid;
      end
   end

   // Output register payload.
   always_ff @(posedge clock) begin
      if (d_ready) begin
         res_re_ff <= res_re_in;
         res_im_ff <= res_im_in;
         ovf_ff    <= ovf_re || ovf_im;
         dz_ff     <= d_flags.div_by_zero;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.res_re      = res_re_ff;
   assign rsp_chan.res_im      = res_im_ff;
   assign rsp_chan.overflow    = ovf_ff;
   assign rsp_chan.div_by_zero = dz_ff;

endmodule
`default_nettype wire
